// File: rtl/hti_pkg.sv
// Shared types, constants and a helper function of the hexahedron displacement interpolator.
package hti_pkg;

  localparam int unsigned NUM_CORNERS = 8;
  localparam int unsigned CORNER_W    = $clog2(NUM_CORNERS);

  localparam int unsigned NAT_W   = 16;  // Q1.14 natural coordinate
  localparam int unsigned FACT_W  = 16;  // 0 .. 32768
  localparam int unsigned POS_W   = 32;  // Q16.16 position
  localparam int unsigned DIFF_W  = POS_W + 1;
  localparam int unsigned P1_W    = 31;  // fx*fy, up to 2^30
  localparam int unsigned P2_W    = 46;  // fx*fy*fz, up to 2^45
  localparam int unsigned WGT_W   = 31;  // Q1.30 weight, up to 2^30
  localparam int unsigned PROD_W  = 64;  // weight * diff
  localparam int unsigned SUM_W   = 48;  // running sum, units of 2^-27
  localparam int unsigned RND_W   = 38;  // sum rounded to Q16.16 plus guard

  localparam int unsigned W_SHIFT = 15;
  localparam int unsigned T_SHIFT = 19;
  localparam int unsigned O_SHIFT = 11;

  localparam logic signed [NAT_W:0] ONE_Q14 = 17'sd16384;

  typedef enum logic [1:0] {
    AXIS_X,
    AXIS_Y,
    AXIS_Z
  } hti_axis_t;

  // Controller to datapath
  typedef struct packed {
    logic                load;
    logic [CORNER_W-1:0] corner;
    logic                wmul1;
    logic                wmul2;
    logic                wrnd;
    logic                mul_en;
    hti_axis_t           mul_sel;
    logic                acc_en;
    hti_axis_t           acc_sel;
    logic                emit;
  } hti_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic out_free;
  } hti_sts_t;

  // Clamp a Q1.14 coordinate to [-1, 1] and form 1 + s*p.
  function automatic logic [FACT_W-1:0] nat_factor(input logic signed [NAT_W-1:0] p,
                                                   input logic plus);
    logic signed [NAT_W:0] pc;
    logic signed [NAT_W:0] f;
    pc = {p[NAT_W-1], p};
    if (pc > ONE_Q14) begin
      pc = ONE_Q14;
    end else if (pc < -ONE_Q14) begin
      pc = -ONE_Q14;
    end
    f = plus ? (ONE_Q14 + pc) : (ONE_Q14 - pc);
    return f[FACT_W-1:0];
  endfunction

endpackage

// File: rtl/hti_ctrl.sv
// Sequencer of the hexahedron interpolator: corner count and per-item step control.
module hti_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  hti_pkg::hti_sts_t sts,
  output hti_pkg::hti_cmd_t cmd
);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_WMUL1,
    ST_WMUL2,
    ST_WRND,
    ST_AX0,
    ST_AX1,
    ST_AX2,
    ST_ACC2,
    ST_EMIT
  } state_t;

  state_t                       state_r, state_nxt;
  logic [hti_pkg::CORNER_W-1:0] corner_r, corner_nxt;
  logic                         last_corner;

  assign last_corner = (corner_r == hti_pkg::CORNER_W'(hti_pkg::NUM_CORNERS - 1));
  assign in_ready    = (state_r == ST_IDLE);

  always_comb begin
    state_nxt   = state_r;
    corner_nxt  = corner_r;
    cmd         = '0;
    cmd.corner  = corner_r;
    cmd.mul_sel = hti_pkg::AXIS_X;
    cmd.acc_sel = hti_pkg::AXIS_X;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = ST_WMUL1;
        end
      end
      ST_WMUL1: begin
        cmd.wmul1 = 1'b1;
        state_nxt = ST_WMUL2;
      end
      ST_WMUL2: begin
        cmd.wmul2 = 1'b1;
        state_nxt = ST_WRND;
      end
      ST_WRND: begin
        cmd.wrnd  = 1'b1;
        state_nxt = ST_AX0;
      end
      ST_AX0: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = hti_pkg::AXIS_X;
        state_nxt   = ST_AX1;
      end
      ST_AX1: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = hti_pkg::AXIS_Y;
        cmd.acc_en  = 1'b1;
        cmd.acc_sel = hti_pkg::AXIS_X;
        state_nxt   = ST_AX2;
      end
      ST_AX2: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = hti_pkg::AXIS_Z;
        cmd.acc_en  = 1'b1;
        cmd.acc_sel = hti_pkg::AXIS_Y;
        state_nxt   = ST_ACC2;
      end
      ST_ACC2: begin
        cmd.acc_en  = 1'b1;
        cmd.acc_sel = hti_pkg::AXIS_Z;
        if (last_corner) begin
          state_nxt = ST_EMIT;
        end else begin
          corner_nxt = corner_r + 1'b1;
          state_nxt  = ST_IDLE;
        end
      end
      ST_EMIT: begin
        // hold until the output register is free
        if (sts.out_free) begin
          cmd.emit   = 1'b1;
          corner_nxt = '0;
          state_nxt  = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      corner_r <= '0;
    end else begin
      state_r  <= state_nxt;
      corner_r <= corner_nxt;
    end
  end

endmodule

// File: rtl/hti_dp.sv
// Datapath of the hexahedron interpolator: weight product, shared axis multiplier, sums, output.
module hti_dp (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  hti_pkg::hti_cmd_t                    cmd,
  output hti_pkg::hti_sts_t                    sts,
  input  logic signed [hti_pkg::NAT_W-1:0]     in_nat_x,
  input  logic signed [hti_pkg::NAT_W-1:0]     in_nat_y,
  input  logic signed [hti_pkg::NAT_W-1:0]     in_nat_z,
  input  logic signed [hti_pkg::POS_W-1:0]     in_def_x,
  input  logic signed [hti_pkg::POS_W-1:0]     in_def_y,
  input  logic signed [hti_pkg::POS_W-1:0]     in_def_z,
  input  logic signed [hti_pkg::POS_W-1:0]     in_rest_x,
  input  logic signed [hti_pkg::POS_W-1:0]     in_rest_y,
  input  logic signed [hti_pkg::POS_W-1:0]     in_rest_z,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic signed [hti_pkg::POS_W-1:0]     out_disp_x,
  output logic signed [hti_pkg::POS_W-1:0]     out_disp_y,
  output logic signed [hti_pkg::POS_W-1:0]     out_disp_z,
  output logic                                 out_sat_flag
);

  localparam int unsigned CW = hti_pkg::CORNER_W;

  logic        [hti_pkg::FACT_W-1:0]  fx_r, fy_r, fz_r;
  logic signed [hti_pkg::DIFF_W-1:0]  diff_r [3];
  logic        [hti_pkg::P1_W-1:0]    p1_r;
  logic        [hti_pkg::P2_W-1:0]    p2_r;
  logic        [hti_pkg::WGT_W-1:0]   w_r;
  logic signed [hti_pkg::PROD_W-1:0]  prod_r;
  logic signed [hti_pkg::SUM_W-1:0]   sum_r [3];

  logic signed [hti_pkg::DIFF_W-1:0]  mul_b;
  logic signed [hti_pkg::PROD_W:0]    prod_full;
  logic signed [hti_pkg::SUM_W-1:0]   acc_old;
  logic signed [hti_pkg::SUM_W-1:0]   acc_new;
  logic signed [hti_pkg::SUM_W-1:0]   term;

  logic signed [hti_pkg::POS_W-1:0]   res [3];
  logic        [2:0]                  clip;

  logic                               out_valid_r;
  logic signed [hti_pkg::POS_W-1:0]   disp_x_r, disp_y_r, disp_z_r;
  logic                               sat_r;

  assign sts.out_free = !out_valid_r || out_ready;

  // Load: clamp coordinates into factors, form exact differences
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      fx_r      <= hti_pkg::nat_factor(in_nat_x, cmd.corner[CW-1]);
      fy_r      <= hti_pkg::nat_factor(in_nat_y, cmd.corner[CW-2]);
      fz_r      <= hti_pkg::nat_factor(in_nat_z, cmd.corner[CW-3]);
      diff_r[0] <= {in_def_x[hti_pkg::POS_W-1], in_def_x}
                 - {in_rest_x[hti_pkg::POS_W-1], in_rest_x};
      diff_r[1] <= {in_def_y[hti_pkg::POS_W-1], in_def_y}
                 - {in_rest_y[hti_pkg::POS_W-1], in_rest_y};
      diff_r[2] <= {in_def_z[hti_pkg::POS_W-1], in_def_z}
                 - {in_rest_z[hti_pkg::POS_W-1], in_rest_z};
    end
  end

  // Weight: two registered products, then round half up by 2^15
  always_ff @(posedge clk) begin
    if (cmd.wmul1) begin
      p1_r <= hti_pkg::P1_W'(32'(fx_r) * 32'(fy_r));
    end
    if (cmd.wmul2) begin
      p2_r <= hti_pkg::P2_W'(48'(p1_r) * 48'(fz_r));
    end
    if (cmd.wrnd) begin
      w_r <= p2_r[hti_pkg::P2_W-1:hti_pkg::W_SHIFT]
           + hti_pkg::WGT_W'(p2_r[hti_pkg::W_SHIFT-1]);
    end
  end

  // Shared axis multiplier
  always_comb begin
    case (cmd.mul_sel)
      hti_pkg::AXIS_X: mul_b = diff_r[0];
      hti_pkg::AXIS_Y: mul_b = diff_r[1];
      hti_pkg::AXIS_Z: mul_b = diff_r[2];
      default:         mul_b = diff_r[0];
    endcase
  end

  assign prod_full = $signed({1'b0, w_r}) * mul_b;

  always_ff @(posedge clk) begin
    if (cmd.mul_en) begin
      prod_r <= prod_full[hti_pkg::PROD_W-1:0];
    end
  end

  // Term rounding folds into the accumulate as a carry-in
  always_comb begin
    case (cmd.acc_sel)
      hti_pkg::AXIS_X: acc_old = sum_r[0];
      hti_pkg::AXIS_Y: acc_old = sum_r[1];
      hti_pkg::AXIS_Z: acc_old = sum_r[2];
      default:         acc_old = sum_r[0];
    endcase
    term    = hti_pkg::SUM_W'(signed'(prod_r[hti_pkg::PROD_W-1:hti_pkg::T_SHIFT]));
    acc_new = acc_old + term + hti_pkg::SUM_W'(prod_r[hti_pkg::T_SHIFT-1]);
  end

  // Output rounding and saturation
  always_comb begin
    logic signed [hti_pkg::RND_W-1:0] rnd;
    for (int a = 0; a < 3; a++) begin
      rnd = hti_pkg::RND_W'(signed'(sum_r[a][hti_pkg::SUM_W-1:hti_pkg::O_SHIFT]))
          + hti_pkg::RND_W'({1'b0, sum_r[a][hti_pkg::O_SHIFT-1]});
      if (rnd > hti_pkg::RND_W'(signed'(33'sh0_7FFF_FFFF))) begin
        res[a]  = {1'b0, {(hti_pkg::POS_W-1){1'b1}}};
        clip[a] = 1'b1;
      end else if (rnd < hti_pkg::RND_W'(signed'(33'sh1_8000_0000))) begin
        res[a]  = {1'b1, {(hti_pkg::POS_W-1){1'b0}}};
        clip[a] = 1'b1;
      end else begin
        res[a]  = rnd[hti_pkg::POS_W-1:0];
        clip[a] = 1'b0;
      end
    end
  end

  // Running sums: clear on reset and after each emitted result
  always_ff @(posedge clk) begin
    if (!rst_n || cmd.emit) begin
      sum_r[0] <= '0;
      sum_r[1] <= '0;
      sum_r[2] <= '0;
    end else if (cmd.acc_en) begin
      case (cmd.acc_sel)
        hti_pkg::AXIS_X: sum_r[0] <= acc_new;
        hti_pkg::AXIS_Y: sum_r[1] <= acc_new;
        hti_pkg::AXIS_Z: sum_r[2] <= acc_new;
        default:         sum_r[0] <= acc_new;
      endcase
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      disp_x_r <= res[0];
      disp_y_r <= res[1];
      disp_z_r <= res[2];
      sat_r    <= |clip;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_disp_x   = disp_x_r;
  assign out_disp_y   = disp_y_r;
  assign out_disp_z   = disp_z_r;
  assign out_sat_flag = sat_r;

endmodule

// File: rtl/hex_trilinear_displacement_interp.sv
// Top level of the trilinear hexahedron displacement interpolator.
//
// Feed the eight corners of one hexahedral element, corner 0 first, one beat
// per corner; corner i takes sign +1 on x, y, z where bits 2, 1, 0 of i are
// set, else -1. Each beat carries the query point in natural coordinates
// (Q1.14, clamped to [-1, 1]) and that corner's deformed and rest positions
// (Q16.16). Each corner adds w * (deformed - rest) to a per-axis sum, where
// w = (1/8)(1 + sx*px)(1 + sy*py)(1 + sz*pz) is rounded to Q1.30. After the
// eighth corner one result beat carries the displacement in Q16.16, rounded
// half up and clipped to 32 bits, with sat_flag high if any axis was clipped;
// the sums then clear for the next element. A corner beat is taken only in
// idle: in_ready drops at acceptance and rises again once the sequencer is
// back in idle. Three steps build the weight (two products and a rounding),
// then one shared multiplier serves the three axes in turn, its products
// registered and fed to the accumulator in the following cycle. The eighth
// corner then passes an emit state that loads the output register, and waits
// there while a previous result is still held. A result held in the output
// register does not stop the next element's corners from being taken; only
// their eighth corner waits. A result beat appears as the emit state loads it,
// at the edge where in_ready rises again; a held previous result delays it.
module hex_trilinear_displacement_interp (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic signed [hti_pkg::NAT_W-1:0]  in_nat_x,
  input  logic signed [hti_pkg::NAT_W-1:0]  in_nat_y,
  input  logic signed [hti_pkg::NAT_W-1:0]  in_nat_z,
  input  logic signed [hti_pkg::POS_W-1:0]  in_def_x,
  input  logic signed [hti_pkg::POS_W-1:0]  in_def_y,
  input  logic signed [hti_pkg::POS_W-1:0]  in_def_z,
  input  logic signed [hti_pkg::POS_W-1:0]  in_rest_x,
  input  logic signed [hti_pkg::POS_W-1:0]  in_rest_y,
  input  logic signed [hti_pkg::POS_W-1:0]  in_rest_z,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic signed [hti_pkg::POS_W-1:0]  out_disp_x,
  output logic signed [hti_pkg::POS_W-1:0]  out_disp_y,
  output logic signed [hti_pkg::POS_W-1:0]  out_disp_z,
  output logic                              out_sat_flag
);

  hti_pkg::hti_cmd_t cmd;
  hti_pkg::hti_sts_t sts;

  // Sequencer: corner count, step order, result hand-off
  hti_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // Arithmetic, running sums and the output register
  hti_dp u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (cmd),
    .sts          (sts),
    .in_nat_x     (in_nat_x),
    .in_nat_y     (in_nat_y),
    .in_nat_z     (in_nat_z),
    .in_def_x     (in_def_x),
    .in_def_y     (in_def_y),
    .in_def_z     (in_def_z),
    .in_rest_x    (in_rest_x),
    .in_rest_y    (in_rest_y),
    .in_rest_z    (in_rest_z),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_disp_x   (out_disp_x),
    .out_disp_y   (out_disp_y),
    .out_disp_z   (out_disp_z),
    .out_sat_flag (out_sat_flag)
  );

endmodule

// File: rtl/hti_checker.sv
// Port-level checker of the hexahedron interpolator and its bind to the top level.
module hti_checker (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              in_valid,
  input logic                              in_ready,
  input logic                              out_valid,
  input logic                              out_ready,
  input logic signed [hti_pkg::POS_W-1:0]  out_disp_x,
  input logic signed [hti_pkg::POS_W-1:0]  out_disp_y,
  input logic signed [hti_pkg::POS_W-1:0]  out_disp_z,
  input logic                              out_sat_flag
);

  localparam logic signed [hti_pkg::POS_W-1:0] POS_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [hti_pkg::POS_W-1:0] POS_MIN = 32'sh8000_0000;

  // A held result beat keeps its payload
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_disp_x)
      && $stable(out_disp_y) && $stable(out_disp_z) && $stable(out_sat_flag))
    else $error("result beat changed while stalled");

  // One corner at a time: ready drops after every accepted beat
  a_in_one: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input ready stayed high after an accepted beat");

  // The flag means some axis sits at a rail
  a_sat: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_sat_flag |->
      out_disp_x == POS_MAX || out_disp_x == POS_MIN ||
      out_disp_y == POS_MAX || out_disp_y == POS_MIN ||
      out_disp_z == POS_MAX || out_disp_z == POS_MIN)
    else $error("saturation flag without a clipped axis");

  // Reset leaves no result and an open input
  a_reset: assert property (@(posedge clk)
    !rst_n |=> !out_valid && in_ready)
    else $error("block not idle after reset");

endmodule

bind hex_trilinear_displacement_interp hti_checker u_hti_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_valid     (in_valid),
  .in_ready     (in_ready),
  .out_valid    (out_valid),
  .out_ready    (out_ready),
  .out_disp_x   (out_disp_x),
  .out_disp_y   (out_disp_y),
  .out_disp_z   (out_disp_z),
  .out_sat_flag (out_sat_flag)
);
